// ----- sv/lidar_gap_follower_defines.svh -----
// Assertion macros of the lidar gap follower, used by lgf_ctrl
`ifndef LIDAR_GAP_FOLLOWER_DEFINES_SVH
`define LIDAR_GAP_FOLLOWER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LGF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lgf_pkg.sv -----
// Shared types and constants of the lidar gap follower
`default_nettype none
package lgf_pkg;
  typedef logic [15:0]        range_t;
  typedef logic [9:0]         cidx_t;
  typedef logic [10:0]        gidx_t;
  typedef logic signed [11:0] head_t;
  typedef logic [9:0]         kstart_t;
  typedef logic [10:0]        kcount_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_MAX_RANGE = 3'd0;
  localparam logic [2:0] REG_BUBBLE    = 3'd1;
  localparam logic [2:0] REG_MIN_GAP   = 3'd2;
  localparam logic [2:0] REG_KSTART    = 3'd3;
  localparam logic [2:0] REG_KCOUNT    = 3'd4;

  localparam range_t  RST_MAX_RANGE = 16'd30000;
  localparam range_t  RST_BUBBLE    = 16'd450;
  localparam range_t  RST_MIN_GAP   = 16'd500;
  localparam kstart_t RST_KSTART    = 10'd0;
  localparam kcount_t RST_KCOUNT    = 11'd1024;

  localparam logic [10:0] SAMPLE_CTR_MAX = 11'd2047;

  // scan passes
  localparam logic [1:0] PASS_SMOOTH = 2'd0;
  localparam logic [1:0] PASS_BUBBLE = 2'd1;
  localparam logic [1:0] PASS_GAP    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       rd;
    logic [1:0] pass;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic too_few;
    logic out_free;
  } status_t;
endpackage
`default_nettype wire

// ----- sv/lgf_if.sv -----
// Sample and result channel interfaces
`default_nettype none
interface lgf_in_if;
  logic                 valid;
  logic                 ready;
  lgf_pkg::range_t      range_mm;
  logic                 is_nan;
  logic                 is_inf;
  logic                 last;
  modport source (output valid, range_mm, is_nan, is_inf, last, input ready);
  modport sink   (input valid, range_mm, is_nan, is_inf, last, output ready);
endinterface

interface lgf_out_if;
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  lgf_pkg::cidx_t       near_index;
  lgf_pkg::gidx_t       gap_start;
  lgf_pkg::gidx_t       gap_end;
  lgf_pkg::gidx_t       target_index;
  lgf_pkg::head_t       heading_error;
  lgf_pkg::range_t      gap_peak_mm;
  modport source (output valid, valid_res, near_index, gap_start, gap_end,
                  target_index, heading_error, gap_peak_mm, input ready);
  modport sink   (input valid, valid_res, near_index, gap_start, gap_end,
                  target_index, heading_error, gap_peak_mm, output ready);
endinterface
`default_nettype wire

// ----- sv/lgf_ram.sv -----
// Generic one-write one-read RAM with registered read data
`default_nettype none
module lgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- sv/lgf_ctrl.sv -----
// Sequencer of load, smoothing, bubble and gap passes
`default_nettype none
`include "lidar_gap_follower_defines.svh"
module lgf_ctrl #(
  parameter int MAX_POINTS  = 1024,
  parameter int WINDOW_HALF = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lgf_pkg::status_t              status,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0] kept_n,
  output lgf_pkg::cmd_t                      cmd,
  output logic [$clog2(MAX_POINTS)-1:0]      rd_addr
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = 2 * WINDOW_HALF;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PASS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    drn_r, drn_nxt;
  logic [1:0]    pass_r, pass_nxt;
  logic [CW-1:0] len;

  assign len     = (pass_r == lgf_pkg::PASS_SMOOTH) ? kept_n : kept_n - CW'(TW);
  assign rd_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    drn_nxt   = drn_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.pass  = pass_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.last_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.init = 1'b1;
        idx_nxt  = '0;
        pass_nxt = lgf_pkg::PASS_SMOOTH;
        state_nxt = status.too_few ? S_EMIT : S_PASS;
      end
      S_PASS: begin
        cmd.rd  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == len - 1'b1) begin
          state_nxt = S_DRAIN;
          drn_nxt   = '0;
        end
      end
      S_DRAIN: begin
        drn_nxt = drn_r + 1'b1;
        if (drn_r == DRAIN_LAST) begin
          idx_nxt = '0;
          unique case (pass_r)
            lgf_pkg::PASS_SMOOTH: begin
              pass_nxt  = lgf_pkg::PASS_BUBBLE;
              state_nxt = S_PASS;
            end
            lgf_pkg::PASS_BUBBLE: begin
              pass_nxt  = lgf_pkg::PASS_GAP;
              state_nxt = S_PASS;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      idx_r   <= '0;
      drn_r   <= '0;
      pass_r  <= lgf_pkg::PASS_SMOOTH;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drn_r   <= drn_nxt;
      pass_r  <= pass_nxt;
    end
  end

  `LGF_ASSERT_NOW(a_no_read_in_load, cmd.load, !cmd.rd, "read issued while loading")
  `LGF_ASSERT_NOW(a_emit_when_free, cmd.emit, status.out_free, "emit into busy output")
  `LGF_ASSERT_NEXT(a_emit_then_load, cmd.emit, cmd.load, "no return to load after emit")
  `LGF_ASSERT_NOW(a_read_in_scan, cmd.rd, {1'b0, rd_addr} < (AW+1)'(kept_n),
                  "read beyond kept samples")
endmodule
`default_nettype wire

// ----- sv/lgf_dp.sv -----
// Sample stores, sliding minimum, bubble and gap trackers, result register
`default_nettype none
module lgf_dp #(
  parameter int MAX_POINTS  = 1024,
  parameter int WINDOW_HALF = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lgf_pkg::range_t                 max_range_mm,
  input  wire lgf_pkg::range_t                 bubble_radius_mm,
  input  wire lgf_pkg::range_t                 min_gap_mm,
  input  wire lgf_pkg::kstart_t                keep_start,
  input  wire lgf_pkg::kcount_t                keep_count,
  input  wire logic                            in_valid,
  input  wire lgf_pkg::range_t                 in_range_mm,
  input  wire logic                            in_is_nan,
  input  wire logic                            in_is_inf,
  input  wire logic                            in_last,
  input  wire lgf_pkg::cmd_t                   cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  output lgf_pkg::status_t                     status,
  output logic [$clog2(MAX_POINTS+1)-1:0]      kept_n,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 out_valid_res,
  output lgf_pkg::cidx_t                       out_near_index,
  output lgf_pkg::gidx_t                       out_gap_start,
  output lgf_pkg::gidx_t                       out_gap_end,
  output lgf_pkg::gidx_t                       out_target_index,
  output lgf_pkg::head_t                       out_heading_error,
  output lgf_pkg::range_t                      out_gap_peak_mm
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = 2 * WINDOW_HALF;
  localparam int TP = 2 ** $clog2(TW + 1);

  // ---- load ----
  logic [10:0]   sc_r;
  logic [CW-1:0] kn_r;
  logic          acc, keep;
  lgf_pkg::range_t clean;

  assign acc  = in_valid && cmd.load;
  assign keep = (sc_r >= {1'b0, keep_start}) &&
                ({1'b0, sc_r} < ({2'b0, keep_start} + {1'b0, keep_count})) &&
                (kn_r < CW'(MAX_POINTS));

  always_comb begin
    if (in_is_nan) begin
      clean = '0;
    end else if (in_is_inf || (in_range_mm > max_range_mm)) begin
      clean = max_range_mm;
    end else begin
      clean = in_range_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
      kn_r <= '0;
    end else if (cmd.emit) begin
      sc_r <= '0;
      kn_r <= '0;
    end else if (acc) begin
      if (keep) begin
        kn_r <= kn_r + 1'b1;
      end
      if (sc_r < lgf_pkg::SAMPLE_CTR_MAX) begin
        sc_r <= sc_r + 1'b1;
      end
    end
  end

  assign kept_n = kn_r;

  logic [CW-1:0] m;
  assign m = kn_r - CW'(TW);

  // ---- stores ----
  lgf_pkg::range_t kept_rdata, sm_rdata, sm_wdata;
  logic            sm_we;
  logic [AW-1:0]   sm_waddr;

  lgf_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_kept (
    .clk   (clk),
    .we    (acc && keep),
    .waddr (kn_r[AW-1:0]),
    .wdata (clean),
    .re    (cmd.rd && (cmd.pass == lgf_pkg::PASS_SMOOTH)),
    .raddr (rd_addr),
    .rdata (kept_rdata)
  );

  lgf_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_smooth (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (cmd.rd && (cmd.pass != lgf_pkg::PASS_SMOOTH)),
    .raddr (rd_addr),
    .rdata (sm_rdata)
  );

  // read pipeline tags
  logic          rv_r;
  logic [1:0]    rpass_r;
  logic [AW-1:0] ridx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd;
    end
    rpass_r <= cmd.pass;
    ridx_r  <= rd_addr;
  end

  // ---- sliding minimum ----
  lgf_pkg::range_t taps_r [0:TW];
  logic            tv_r;
  logic [CW-1:0]   tidx_r;
  lgf_pkg::range_t red [0:2*TP-2];
  lgf_pkg::range_t win_min;
  lgf_pkg::range_t min_r;
  logic [AW-1:0]   c_r;

  always_comb begin
    for (int i = 0; i < TP; i++) begin
      red[TP-1+i] = '1;
    end
    for (int i = 0; i <= TW; i++) begin
      red[TP-1+i] = taps_r[i];
    end
    for (int i = TP - 2; i >= 0; i--) begin
      red[i] = (red[2*i+2] < red[2*i+1]) ? red[2*i+2] : red[2*i+1];
    end
  end
  assign win_min = red[0];

  assign sm_we    = tv_r && (tidx_r >= CW'(TW));
  assign sm_waddr = AW'(tidx_r - CW'(TW));
  assign sm_wdata = win_min;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= rv_r && (rpass_r == lgf_pkg::PASS_SMOOTH);
    end
    if (rv_r && (rpass_r == lgf_pkg::PASS_SMOOTH)) begin
      taps_r[0] <= kept_rdata;
      for (int k = 1; k <= TW; k++) begin
        taps_r[k] <= taps_r[k-1];
      end
      tidx_r <= CW'(ridx_r);
    end
    if (cmd.init) begin
      min_r <= '1;
      c_r   <= '0;
    end else if (sm_we && (win_min < min_r)) begin
      min_r <= win_min;
      c_r   <= sm_waddr;
    end
  end

  // ---- bubble bounds ----
  logic [16:0]   thr;
  logic          le;
  logic [CW-1:0] run_r, bl_r, br_r;
  logic          br_set_r;

  assign thr = {1'b0, min_r} + {1'b0, bubble_radius_mm};
  assign le  = {1'b0, sm_rdata} <= thr;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      run_r    <= '0;
      bl_r     <= '0;
      br_r     <= m;
      br_set_r <= 1'b0;
    end else if (rv_r && (rpass_r == lgf_pkg::PASS_BUBBLE)) begin
      if (!le) begin
        run_r <= CW'(ridx_r) + 1'b1;
      end
      if (ridx_r == c_r) begin
        bl_r <= run_r;
      end
      if ((ridx_r > c_r) && !le && !br_set_r) begin
        br_r     <= CW'(ridx_r);
        br_set_r <= 1'b1;
      end
    end
  end

  // ---- longest gap ----
  lgf_pkg::range_t v, cpk_r, bpk_r;
  logic            g;
  logic [CW-1:0]   cst_r, csz_r, bst_r, bsz_r;

  assign v = ((CW'(ridx_r) >= bl_r) && (CW'(ridx_r) < br_r)) ? '0 : sm_rdata;
  assign g = v > min_gap_mm;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cst_r <= '0;
      csz_r <= '0;
      cpk_r <= '0;
      bst_r <= '0;
      bsz_r <= '0;
      bpk_r <= '0;
    end else if (rv_r && (rpass_r == lgf_pkg::PASS_GAP)) begin
      if (g) begin
        if (csz_r == '0) begin
          cst_r <= CW'(ridx_r);
          cpk_r <= v;
        end else if (v > cpk_r) begin
          cpk_r <= v;
        end
        csz_r <= csz_r + 1'b1;
      end else begin
        if (csz_r > bsz_r) begin
          bst_r <= cst_r;
          bsz_r <= csz_r;
          bpk_r <= cpk_r;
        end
        csz_r <= '0;
      end
    end
  end

  // ---- result ----
  logic            fin_cur;
  logic [CW-1:0]   fst, fsz, fend, ftgt;
  lgf_pkg::range_t fpk;

  assign fin_cur = csz_r > bsz_r;
  assign fst     = fin_cur ? cst_r : bst_r;
  assign fsz     = fin_cur ? csz_r : bsz_r;
  assign fpk     = fin_cur ? cpk_r : bpk_r;
  assign fend    = fst + fsz;
  assign ftgt    = CW'(({1'b0, fst} + {1'b0, fend}) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      if (status.too_few) begin
        out_valid_res     <= 1'b0;
        out_near_index    <= '0;
        out_gap_start     <= '0;
        out_gap_end       <= '0;
        out_target_index  <= '0;
        out_heading_error <= '0;
        out_gap_peak_mm   <= '0;
      end else begin
        out_valid_res     <= 1'b1;
        out_near_index    <= lgf_pkg::cidx_t'(c_r);
        out_gap_start     <= lgf_pkg::gidx_t'(fst);
        out_gap_end       <= lgf_pkg::gidx_t'(fend);
        out_target_index  <= lgf_pkg::gidx_t'(ftgt);
        out_heading_error <= lgf_pkg::head_t'(int'(ftgt) - int'(m >> 1));
        out_gap_peak_mm   <= fpk;
      end
    end
  end

  assign status.last_acc = acc && in_last;
  assign status.too_few  = kn_r <= CW'(TW);
  assign status.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

// ----- sv/lidar_gap_follower.sv -----
// Lidar follow-the-gap analyser: top level with configuration registers
// Use:
//  - in_ch carries one range sample per transfer, in scan order; last marks
//    the final sample of a scan. Samples load at one per cycle.
//  - After the last sample, in_ch.ready drops while the scan is processed:
//    smoothing pass (n reads), bubble pass (m = n - 2*WINDOW_HALF reads) and
//    gap pass (m reads), each followed by drain states. Each sample store has
//    a single read port.
//  - out_ch carries one result per scan; it is held in an output register,
//    and loading of the next scan starts as soon as the result is written.
//  - If out_ch stalls, the result holds; a second scan finishes its passes
//    and then waits until the first result has been taken.
//  - Reset (synchronous, active low) clears counters, the sequencer and the
//    output valid; registers return to their defaults. Sample stores need
//    no clearing: only entries written in the current scan are read.
//  - Registers sit at byte address 4*i; pready is always high.
`default_nettype none
module lidar_gap_follower #(
  parameter int MAX_POINTS  = 1024,
  parameter int WINDOW_HALF = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lgf_in_if.sink             in_ch,
  lgf_out_if.source          out_ch,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // configuration registers
  lgf_pkg::range_t  max_range_r, bubble_r, min_gap_r;
  lgf_pkg::kstart_t kstart_r;
  lgf_pkg::kcount_t kcount_r;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r <= lgf_pkg::RST_MAX_RANGE;
      bubble_r    <= lgf_pkg::RST_BUBBLE;
      min_gap_r   <= lgf_pkg::RST_MIN_GAP;
      kstart_r    <= lgf_pkg::RST_KSTART;
      kcount_r    <= lgf_pkg::RST_KCOUNT;
    end else if (wr) begin
      unique case (paddr[4:2])
        lgf_pkg::REG_MAX_RANGE: max_range_r <= pwdata[15:0];
        lgf_pkg::REG_BUBBLE:    bubble_r    <= pwdata[15:0];
        lgf_pkg::REG_MIN_GAP:   min_gap_r   <= pwdata[15:0];
        lgf_pkg::REG_KSTART:    kstart_r    <= pwdata[9:0];
        lgf_pkg::REG_KCOUNT:    kcount_r    <= pwdata[10:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      lgf_pkg::REG_MAX_RANGE: prdata = {16'd0, max_range_r};
      lgf_pkg::REG_BUBBLE:    prdata = {16'd0, bubble_r};
      lgf_pkg::REG_MIN_GAP:   prdata = {16'd0, min_gap_r};
      lgf_pkg::REG_KSTART:    prdata = {22'd0, kstart_r};
      lgf_pkg::REG_KCOUNT:    prdata = {21'd0, kcount_r};
      default:                prdata = '0;
    endcase
  end

  // sequencer and datapath joined by command and status
  lgf_pkg::cmd_t    cmd;
  lgf_pkg::status_t status;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    kept_n;

  // take a sample transfer only while loading
  assign in_ch.ready = cmd.load;

  lgf_ctrl #(.MAX_POINTS(MAX_POINTS), .WINDOW_HALF(WINDOW_HALF)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .status  (status),
    .kept_n  (kept_n),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  lgf_dp #(.MAX_POINTS(MAX_POINTS), .WINDOW_HALF(WINDOW_HALF)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_range_mm      (max_range_r),
    .bubble_radius_mm  (bubble_r),
    .min_gap_mm        (min_gap_r),
    .keep_start        (kstart_r),
    .keep_count        (kcount_r),
    .in_valid          (in_ch.valid),
    .in_range_mm       (in_ch.range_mm),
    .in_is_nan         (in_ch.is_nan),
    .in_is_inf         (in_ch.is_inf),
    .in_last           (in_ch.last),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .status            (status),
    .kept_n            (kept_n),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_valid_res     (out_ch.valid_res),
    .out_near_index    (out_ch.near_index),
    .out_gap_start     (out_ch.gap_start),
    .out_gap_end       (out_ch.gap_end),
    .out_target_index  (out_ch.target_index),
    .out_heading_error (out_ch.heading_error),
    .out_gap_peak_mm   (out_ch.gap_peak_mm)
  );
endmodule
`default_nettype wire

// ----- tb/sv/tb_lidar_gap_follower.sv -----
// Self-checking testbench of the lidar gap follower: scans in, gap results checked
`timescale 1ns / 100ps
module tb_lidar_gap_follower;

  localparam int  MAXPTS     = 1024;
  localparam int  WHALF      = 5;
  localparam int  CYCLE_CAP  = 400000;  // far above the slowest correct run
  localparam int  SETTLE     = 60;      // cycles for the sequencer to fall idle

  typedef struct packed {
    logic             valid_res;
    lgf_pkg::cidx_t   near_index;
    lgf_pkg::gidx_t   gap_start;
    lgf_pkg::gidx_t   gap_end;
    lgf_pkg::gidx_t   target_index;
    lgf_pkg::head_t   heading_error;
    lgf_pkg::range_t  gap_peak_mm;
  } gap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;   // when set, neither side idles

  lgf_in_if  in_ch ();
  lgf_out_if out_ch ();

  lidar_gap_follower DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Mirror of the block: register copies, scan stores and counters
  class gap_scoreboard;
    int unsigned max_range, bubble, min_gap, kstart, kcount;
    int unsigned kept[MAXPTS];
    int unsigned scan_idx, kept_cnt;
    gap_result_t awaited[$];

    function new();
      max_range = lgf_pkg::RST_MAX_RANGE; bubble = lgf_pkg::RST_BUBBLE;
      min_gap = lgf_pkg::RST_MIN_GAP;
      kstart = lgf_pkg::RST_KSTART; kcount = lgf_pkg::RST_KCOUNT;
      scan_idx = 0; kept_cnt = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        lgf_pkg::REG_MAX_RANGE: max_range = v[15:0];
        lgf_pkg::REG_BUBBLE:    bubble    = v[15:0];
        lgf_pkg::REG_MIN_GAP:   min_gap   = v[15:0];
        lgf_pkg::REG_KSTART:    kstart    = v[9:0];
        lgf_pkg::REG_KCOUNT:    kcount    = v[10:0];
        default: ;
      endcase
    endfunction

    // Smooth, bubble and search the stored scan for its longest gap
    function gap_result_t analyse_scan();
      gap_result_t r;
      int unsigned sm[MAXPTS];
      int unsigned m, c, thr, mn, bs, bsz, cs, csz, gend, tgt, peak;
      int hd;
      r = '0;
      if (kept_cnt <= 2 * WHALF) return r;
      m = kept_cnt - 2 * WHALF;
      for (int i = 0; i < m; i++) begin
        mn = kept[i];
        for (int k = 1; k <= 2 * WHALF; k++)
          if (kept[i + k] < mn) mn = kept[i + k];
        sm[i] = mn;
      end
      c = 0;
      for (int i = 1; i < m; i++)
        if (sm[i] < sm[c]) c = i;
      thr = sm[c] + bubble;
      sm[c] = 0;
      for (int i = c + 1; i < m; i++) begin
        if (sm[i] > thr) break;
        sm[i] = 0;
      end
      for (int i = c; i > 0; i--) begin
        if (sm[i - 1] > thr) break;
        sm[i - 1] = 0;
      end
      bs = 0; bsz = 0; cs = 0; csz = 0;
      for (int i = 0; i < m; i++) begin
        if (sm[i] > min_gap) begin
          if (csz == 0) cs = i;
          csz++;
        end else begin
          if (csz > bsz) begin
            bs = cs; bsz = csz;
          end
          csz = 0;
        end
      end
      if (csz > bsz) begin
        bs = cs; bsz = csz;
      end
      gend = bs + bsz;
      tgt  = (bs + gend) / 2;
      hd   = int'(tgt) - int'(m / 2);
      peak = 0;
      for (int i = bs; i < gend; i++)
        if (sm[i] > peak) peak = sm[i];
      r.valid_res     = 1'b1;
      r.near_index    = c[9:0];
      r.gap_start     = bs[10:0];
      r.gap_end       = gend[10:0];
      r.target_index  = tgt[10:0];
      r.heading_error = hd[11:0];
      r.gap_peak_mm   = peak[15:0];
      return r;
    endfunction

    function void note_sample(lgf_pkg::range_t rng, logic nan_f, logic inf_f, logic lst);
      int unsigned v;
      if (scan_idx >= kstart && scan_idx < kstart + kcount && kept_cnt < MAXPTS) begin
        if (nan_f) v = 0;
        else if (inf_f || rng > max_range) v = max_range;
        else v = rng;
        kept[kept_cnt] = v;
        kept_cnt++;
      end
      if (scan_idx < lgf_pkg::SAMPLE_CTR_MAX) scan_idx++;
      if (lst) begin
        awaited = {awaited, analyse_scan()};
        scan_idx = 0;
        kept_cnt = 0;
      end
    endfunction

    task check_result(gap_result_t got);
      gap_result_t e;
      if (awaited.size() == 0) begin
        report("result with no scan outstanding");
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (got.valid_res !== e.valid_res)
        report($sformatf("valid_res %0d exp %0d", got.valid_res, e.valid_res));
      if (got.near_index !== e.near_index)
        report($sformatf("near_index %0d exp %0d", got.near_index, e.near_index));
      if (got.gap_start !== e.gap_start)
        report($sformatf("gap_start %0d exp %0d", got.gap_start, e.gap_start));
      if (got.gap_end !== e.gap_end)
        report($sformatf("gap_end %0d exp %0d", got.gap_end, e.gap_end));
      if (got.target_index !== e.target_index)
        report($sformatf("target_index %0d exp %0d", got.target_index, e.target_index));
      if (got.heading_error !== e.heading_error)
        report($sformatf("heading_error %0d exp %0d", got.heading_error, e.heading_error));
      if (got.gap_peak_mm !== e.gap_peak_mm)
        report($sformatf("gap_peak_mm %0d exp %0d", got.gap_peak_mm, e.gap_peak_mm));
    endtask
  endclass

  gap_scoreboard sb = new();

  // Cycle count and hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_lidar_gap_follower NOT OK");
      $finish;
    end
  end

  // Result side: stall at random, check every transfer at the rising edge
  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= calm || ($urandom_range(99) >= 32);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.valid_res, out_ch.near_index, out_ch.gap_start,
                       out_ch.gap_end, out_ch.target_index, out_ch.heading_error,
                       out_ch.gap_peak_mm});
  end

  // Two-phase register write; call only while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_config(int unsigned mr, int unsigned br, int unsigned mg,
                             int unsigned ks, int unsigned kc);
    write_reg(lgf_pkg::REG_MAX_RANGE, mr);
    write_reg(lgf_pkg::REG_BUBBLE, br);
    write_reg(lgf_pkg::REG_MIN_GAP, mg);
    write_reg(lgf_pkg::REG_KSTART, ks);
    write_reg(lgf_pkg::REG_KCOUNT, kc);
  endtask

  // Offer one sample; entered and left at a falling edge
  task automatic send_sample(lgf_pkg::range_t rng, logic nan_f, logic inf_f, logic lst);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.range_mm <= rng; in_ch.is_nan <= nan_f;
    in_ch.is_inf <= inf_f; in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(rng, nan_f, inf_f, lst);
    @(negedge clk);
  endtask

  // One scan shaped like walls and openings, with some noise and bad readings
  task automatic send_scan(int len);
    int unsigned level, hi, roll, noisy;
    lgf_pkg::range_t v;
    hi = sb.max_range + sb.max_range / 4 + 16;
    if (hi > 65535) hi = 65535;
    level = $urandom_range(hi);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) level = $urandom_range(hi);
      roll = $urandom_range(99);
      noisy = level + $urandom_range(200);
      v = (noisy > 65535) ? 16'hFFFF : lgf_pkg::range_t'(noisy);
      if (roll < 8)
        send_sample(lgf_pkg::range_t'($urandom), 1'b1, 1'($urandom_range(1)), i == len - 1);
      else if (roll < 13)
        send_sample(lgf_pkg::range_t'($urandom), 1'b0, 1'b1, i == len - 1);
      else if (roll < 18)
        send_sample(lgf_pkg::range_t'($urandom), 1'b0, 1'b0, i == len - 1);
      else send_sample(v, 1'b0, 1'b0, i == len - 1);
    end
  endtask

  task automatic drain();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int sent;
    in_ch.valid = 1'b0; in_ch.range_mm = '0; in_ch.is_nan = 1'b0;
    in_ch.is_inf = 1'b0; in_ch.last = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single-sample scan, ten samples (too few), then a short scan of extremes
    send_sample(16'hFFFF, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 10; i++)
      send_sample(lgf_pkg::range_t'(1000 + i), 1'b0, 1'b0, i == 9);
    send_sample(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0, 1'b0);
    send_sample(16'd5000, 1'b1, 1'b0, 1'b0);
    send_sample(16'd5000, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++)
      send_sample(lgf_pkg::range_t'(30001 + i * 3000), 1'b0, 1'b0, i == 8);
    in_ch.valid <= 1'b0;
    drain();

    // Extreme settings: everything kept and clamped to full scale, no gap threshold
    load_config(65535, 65535, 0, 0, 1024);
    send_scan(40);
    send_scan(12);
    in_ch.valid <= 1'b0;
    drain();
    // Nothing kept, zero range and bubble, unreachable gap threshold
    load_config(0, 0, 65535, 1023, 0);
    send_scan(30);
    in_ch.valid <= 1'b0;
    drain();

    // Random settings, short scans; the middle phases run without idling
    sent = 0;
    for (int ph = 0; sent < 700; ph++) begin
      calm = (ph == 1 || ph == 2);
      load_config($urandom_range(65535), $urandom_range(3000), $urandom_range(4000),
                  $urandom_range(40), (ph % 5 == 0) ? 1024 : $urandom_range(60));
      for (int s = 0; s < 6; s++) begin
        int len;
        len = $urandom_range(1, 70);
        send_scan(len);
        sent += len;
      end
      in_ch.valid <= 1'b0;
      drain();
    end
    calm = 1'b0;

    // Back to reset values: one long scan saturates the kept counter
    load_config(lgf_pkg::RST_MAX_RANGE, lgf_pkg::RST_BUBBLE, lgf_pkg::RST_MIN_GAP,
                lgf_pkg::RST_KSTART, lgf_pkg::RST_KCOUNT);
    send_scan(1030);
    in_ch.valid <= 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("tb_lidar_gap_follower OK");
    end else begin
      $display("tb_lidar_gap_follower NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/lgf_pkg.sv
sv/lgf_if.sv
sv/lgf_ram.sv
sv/lgf_ctrl.sv
sv/lgf_dp.sv
sv/lidar_gap_follower.sv
tb/sv/tb_lidar_gap_follower.sv
